FILE: hdl/cbc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the clock buffer cache controller.
package cbc_pkg;

   localparam int ENTRIES     = 64;
   localparam int SECTOR_BITS = 32;
   localparam int SLOT_BITS   = $clog2(ENTRIES);
   localparam int TRY_BITS    = $clog2(2 * ENTRIES);

   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(ENTRIES - 1);
   localparam logic [TRY_BITS-1:0]  LAST_TRY  = TRY_BITS'(2 * ENTRIES - 1);

   // command codes
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_ACCESS     = 3'd0;
   localparam logic [2:0] KIND_WRITEBACK  = 3'd1;
   localparam logic [2:0] KIND_FILL       = 3'd2;
   localparam logic [2:0] KIND_FLUSH_DONE = 3'd3;
   localparam logic [2:0] KIND_NO_VICTIM  = 3'd4;

   typedef struct packed {
      logic [1:0]             cmd;
      logic [SECTOR_BITS-1:0] sector;
      logic                   pin_meta;
   } req_type;

   typedef struct packed {
      logic [2:0]             kind;
      logic [SLOT_BITS-1:0]   slot;
      logic [SECTOR_BITS-1:0] sector_out;
      logic                   hit;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic    strobe;
      rsp_type item;
   } emit_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]   rd_addr;
      logic                   wr_en;
      logic [SLOT_BITS-1:0]   wr_addr;
      logic [SECTOR_BITS-1:0] wr_data;
      logic [SECTOR_BITS-1:0] key;
   } tag_ctl_type;

   typedef struct packed {
      logic [SECTOR_BITS-1:0] tag;
      logic                   match;
   } tag_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SWEEP,
      ST_FILL,
      ST_ACCESS,
      ST_FLUSH,
      ST_FLUSH_END
   } state_type;

endpackage

FILE: hdl/cbc_tag_store.sv
`timescale 1ns / 1ps
// Sector tag memory with registered read and the shared tag comparator.
module cbc_tag_store import cbc_pkg::*; (
   input  logic         clock,
   input  tag_ctl_type  ctl,
   output tag_stat_type stat
);

   logic [SECTOR_BITS-1:0] tag_mem [ENTRIES];
   logic [SECTOR_BITS-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         tag_mem[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= tag_mem[ctl.rd_addr];
   end

   assign stat.tag   = rd_ff;
   assign stat.match = (rd_ff == ctl.key);

endmodule

FILE: hdl/cbc_engine.sv
`timescale 1ns / 1ps
// Sequencer: slot flags, clock hand, lookup, victim sweep and flush walk.
module cbc_engine import cbc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_type      req,
   input  tag_stat_type tstat,
   output logic         busy,
   output tag_ctl_type  tctl,
   output emit_type     emit
);

   state_type              state_ff, state_in;
   logic [SLOT_BITS-1:0]   idx_ff, idx_in;
   logic [SLOT_BITS-1:0]   hand_ff, hand_in;
   logic [SLOT_BITS-1:0]   hand_nxt;
   logic [TRY_BITS-1:0]    tries_ff, tries_in;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;
   logic                   hit_ff, hit_in;
   logic [1:0]             cmd_ff, cmd_in;
   logic [SECTOR_BITS-1:0] sector_ff, sector_in;
   logic                   meta_ff, meta_in;
   logic [ENTRIES-1:0]     valid_ff, valid_in;
   logic [ENTRIES-1:0]     dirty_ff, dirty_in;
   logic [ENTRIES-1:0]     accessed_ff, accessed_in;
   logic [ENTRIES-1:0]     pinned_ff, pinned_in;
   logic                   pend_vld_ff, pend_vld_in;
   logic [SLOT_BITS-1:0]   pend_slot_ff, pend_slot_in;
   logic [SECTOR_BITS-1:0] pend_tag_ff, pend_tag_in;

   assign hand_nxt = (hand_ff == LAST_SLOT) ? '0 : hand_ff + 1'b1;
   assign busy     = (state_ff != ST_IDLE);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         hand_ff     <= '0;
         valid_ff    <= '0;
         dirty_ff    <= '0;
         accessed_ff <= '0;
         pinned_ff   <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         hand_ff     <= hand_in;
         valid_ff    <= valid_in;
         dirty_ff    <= dirty_in;
         accessed_ff <= accessed_in;
         pinned_ff   <= pinned_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   // transaction payload
   always_ff @(posedge clock) begin
      tries_ff     <= tries_in;
      slot_ff      <= slot_in;
      hit_ff       <= hit_in;
      cmd_ff       <= cmd_in;
      sector_ff    <= sector_in;
      meta_ff      <= meta_in;
      pend_slot_ff <= pend_slot_in;
      pend_tag_ff  <= pend_tag_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      hand_in      = hand_ff;
      tries_in     = tries_ff;
      slot_in      = slot_ff;
      hit_in       = hit_ff;
      cmd_in       = cmd_ff;
      sector_in    = sector_ff;
      meta_in      = meta_ff;
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      accessed_in  = accessed_ff;
      pinned_in    = pinned_ff;
      pend_vld_in  = pend_vld_ff;
      pend_slot_in = pend_slot_ff;
      pend_tag_in  = pend_tag_ff;
      emit         = '0;
      tctl.wr_en   = 1'b0;
      tctl.wr_addr = slot_ff;
      tctl.wr_data = sector_ff;
      tctl.key     = sector_ff;

      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (start) begin
               cmd_in    = req.cmd;
               sector_in = req.sector;
               meta_in   = req.pin_meta;
               priority if (req.cmd == CMD_READ || req.cmd == CMD_WRITE) begin
                  state_in = ST_LOOKUP;
               end else if (req.cmd == CMD_FLUSH) begin
                  state_in    = ST_FLUSH;
                  pend_vld_in = 1'b0;
               end else begin
                  state_in = ST_IDLE;   // unknown command: dropped
               end
            end
         end

         // tag of slot idx_ff is on tstat this cycle
         ST_LOOKUP: begin
            if (valid_ff[idx_ff] && tstat.match) begin
               slot_in  = idx_ff;
               hit_in   = 1'b1;
               state_in = ST_ACCESS;
            end else if (idx_ff == LAST_SLOT) begin
               idx_in   = hand_ff;
               tries_in = '0;
               state_in = ST_SWEEP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // idx_ff tracks hand_ff here, so tstat.tag is the tag under the hand
         ST_SWEEP: begin
            priority if (!valid_ff[hand_ff]) begin
               slot_in  = hand_ff;
               hit_in   = 1'b0;
               state_in = ST_FILL;
            end else if (!accessed_ff[hand_ff] && !pinned_ff[hand_ff]) begin
               if (dirty_ff[hand_ff]) begin
                  emit.strobe          = 1'b1;
                  emit.item.kind       = KIND_WRITEBACK;
                  emit.item.slot       = hand_ff;
                  emit.item.sector_out = tstat.tag;
                  dirty_in[hand_ff]    = 1'b0;
               end
               valid_in[hand_ff] = 1'b0;
               slot_in           = hand_ff;
               hit_in            = 1'b0;
               state_in          = ST_FILL;
            end else begin
               // second chance for accessed slots, pinned slots skipped
               accessed_in[hand_ff] = 1'b0;
               hand_in              = hand_nxt;
               idx_in               = hand_nxt;
               tries_in             = tries_ff + 1'b1;
               if (tries_ff == LAST_TRY) begin
                  emit.strobe          = 1'b1;
                  emit.item.kind       = KIND_NO_VICTIM;
                  emit.item.slot       = hand_nxt;
                  emit.item.sector_out = sector_ff;
                  emit.item.last       = 1'b1;
                  idx_in               = '0;
                  state_in             = ST_IDLE;
               end
            end
         end

         ST_FILL: begin
            emit.strobe          = 1'b1;
            emit.item.kind       = KIND_FILL;
            emit.item.slot       = slot_ff;
            emit.item.sector_out = sector_ff;
            tctl.wr_en           = 1'b1;
            valid_in[slot_ff]    = 1'b1;
            dirty_in[slot_ff]    = 1'b0;
            pinned_in[slot_ff]   = 1'b0;
            state_in             = ST_ACCESS;
         end

         ST_ACCESS: begin
            emit.strobe          = 1'b1;
            emit.item.kind       = KIND_ACCESS;
            emit.item.slot       = slot_ff;
            emit.item.sector_out = sector_ff;
            emit.item.hit        = hit_ff;
            emit.item.last       = 1'b1;
            accessed_in[slot_ff] = 1'b1;
            if (cmd_ff == CMD_WRITE) begin
               dirty_in[slot_ff]  = 1'b1;
               pinned_in[slot_ff] = meta_ff;
            end
            idx_in   = '0;
            state_in = ST_IDLE;
         end

         // one writeback is held back so the final one can carry last
         ST_FLUSH: begin
            if (valid_ff[idx_ff] && dirty_ff[idx_ff]) begin
               dirty_in[idx_ff] = 1'b0;
               if (pend_vld_ff) begin
                  emit.strobe          = 1'b1;
                  emit.item.kind       = KIND_WRITEBACK;
                  emit.item.slot       = pend_slot_ff;
                  emit.item.sector_out = pend_tag_ff;
               end
               pend_vld_in  = 1'b1;
               pend_slot_in = idx_ff;
               pend_tag_in  = tstat.tag;
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_FLUSH_END;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_FLUSH_END: begin
            emit.strobe    = 1'b1;
            emit.item.last = 1'b1;
            if (pend_vld_ff) begin
               emit.item.kind       = KIND_WRITEBACK;
               emit.item.slot       = pend_slot_ff;
               emit.item.sector_out = pend_tag_ff;
            end else begin
               emit.item.kind = KIND_FLUSH_DONE;
            end
            pend_vld_in = 1'b0;
            idx_in      = '0;
            state_in    = ST_IDLE;
         end

         default: begin
            idx_in   = '0;
            state_in = ST_IDLE;
         end
      endcase

      // read address is idx_in, the next value of idx_ff, so the registered tag lines up with idx_ff
      tctl.rd_addr = idx_in;
   end

endmodule

FILE: hdl/clock_buffer_cache_controller.sv
`timescale 1ns / 1ps
// Top level of the clock second-chance buffer cache tag and policy controller.
//
//  channel  | ports                    | transfer
//  ---------+--------------------------+------------------------------------------
//  request  | start, busy, req_item    | taken on a clock edge with start & !busy
//  response | rsp_strobe, rsp_item     | one result per strobe, cannot be stalled
//
// Sequence: a lookup walks the tag memory one slot per cycle; a hit ends with the
//   access result. A miss walks all slots, then sweeps the clock hand (one slot
//   per cycle through the single tag read port and comparator), then fills and
//   accesses the victim slot or reports that none was found. A flush walks every
//   slot. Results leave through an output register in the next cycle.
// Reset: synchronous, active high; clears all slot flags and the clock hand.
//   Tag memory is not cleared: tags are only used behind a valid flag.
// Stalls: busy is high for the whole transaction; the response side cannot stall.
// Command 3 is accepted and dropped without any result.
module clock_buffer_cache_controller import cbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   tag_ctl_type  tctl;
   tag_stat_type tstat;
   emit_type     emit;

   logic    rsp_strobe_ff;
   rsp_type rsp_item_ff;

   cbc_tag_store u_tag_store (
      .clock (clock),
      .ctl   (tctl),
      .stat  (tstat)
   );

   cbc_engine u_engine (
      .clock (clock),
      .reset (reset),
      .start (start),
      .req   (req_item),
      .tstat (tstat),
      .busy  (busy),
      .tctl  (tctl),
      .emit  (emit)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= emit.strobe;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= emit.item;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // results are only produced inside a transaction
   assert property (@(posedge clock) disable iff (reset) emit.strobe |-> busy)
      else $error("result produced while idle");

   // a fill request is always followed by the access result for the same slot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.kind == KIND_FILL) |=>
         (rsp_strobe && rsp_item.kind == KIND_ACCESS && rsp_item.slot == $past(rsp_item.slot)))
      else $error("fill not followed by access");

   // the final result of a transaction shows up with the controller free again
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last) |-> !busy)
      else $error("last result while still busy");

endmodule
